/* sv/ssdfb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdfb_pkg
// Shared types, command codes and the segment table of the display frame
// builder.
// ----------------------------------------------------------------------------
package ssdfb_pkg;

  // command codes
  localparam logic [2:0] OP_SHOW_INT = 3'd0;
  localparam logic [2:0] OP_SHOW_DEC = 3'd1;
  localparam logic [2:0] OP_RAW      = 3'd2;
  localparam logic [2:0] OP_DISP_ON  = 3'd3;
  localparam logic [2:0] OP_DISP_OFF = 3'd4;
  localparam logic [2:0] OP_INIT     = 3'd5;

  // driver bytes
  localparam logic [5:0] ADDR_CMD_HI  = 6'b110000;  // 0xc0 + address
  localparam logic [7:0] DP_BIT       = 8'h80;
  localparam logic [7:0] CMD_DISP_ON  = 8'h8F;
  localparam logic [7:0] CMD_DISP_OFF = 8'h80;
  localparam logic [7:0] CMD_DATA_SET = 8'h44;

  localparam int NUM_W   = 23;  // truncated hundredths fit in 23 bits
  localparam int DIGIT_W = 14;  // value below 10000

  // reciprocal constants
  localparam logic [18:0] RECIP_625 = 19'd429496;  // floor(2^28 / 625)
  localparam logic [15:0] RECIP_10  = 16'd52429;   // ceil(2^19 / 10)
  localparam logic [9:0]  DIV_625   = 10'd625;

  typedef struct packed {
    logic [2:0]       op;
    logic [7:0]       addr;
    logic [7:0]       seg;
    logic [NUM_W-1:0] n;
  } scale_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         addr;
    logic [7:0]         seg;
    logic [DIGIT_W-1:0] m;
  } digit_t;

  function automatic logic [7:0] seg_lut(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'h0: s = 8'h3f;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5b;
      4'h3: s = 8'h4f;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6d;
      4'h6: s = 8'h7d;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7f;
      4'h9: s = 8'h6f;
      4'ha: s = 8'h77;
      4'hb: s = 8'h7c;
      4'hc: s = 8'h39;
      4'hd: s = 8'h5e;
      4'he: s = 8'h79;
      default: s = 8'h71;
    endcase
    return s;
  endfunction

endpackage

/* sv/ssdfb_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdfb_scale
// Input register and number select: integer low half or hundredths of UQ16.8.
// ----------------------------------------------------------------------------
module ssdfb_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          op_i,
  input  logic [23:0]         value_i,
  input  logic [7:0]          addr_i,
  input  logic [7:0]          seg_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssdfb_pkg::scale_t   out_o
);

  logic        v1_q, v1_d, v2_q, v2_d;
  logic        rdy1, rdy2;
  logic [2:0]  op1_q;
  logic [23:0] val1_q;
  logic [7:0]  addr1_q, seg1_q;
  logic [30:0] prod;
  logic [ssdfb_pkg::NUM_W-1:0] n;
  ssdfb_pkg::scale_t s2_q, s2_d;

  assign rdy2 = !v2_q || out_ready_i;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign v1_d = rdy1 ? in_valid_i : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;

  // value * 100 as shifts and adds, then drop the 8 fraction bits
  assign prod = ({7'd0, val1_q} << 6) + ({7'd0, val1_q} << 5) + ({7'd0, val1_q} << 2);

  always_comb begin
    if (op1_q == ssdfb_pkg::OP_SHOW_DEC) begin
      n = prod[30:8];
    end else begin
      n = {7'd0, val1_q[15:0]};
    end
    s2_d.op   = op1_q;
    s2_d.addr = addr1_q;
    s2_d.seg  = seg1_q;
    s2_d.n    = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      op1_q   <= op_i;
      val1_q  <= value_i;
      addr1_q <= addr_i;
      seg1_q  <= seg_i;
    end
    if (rdy2) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_o       = s2_q;

endmodule

/* sv/ssdfb_mod10k.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdfb_mod10k
// Reduces the number modulo 10000: reciprocal multiply, then one correction.
// ----------------------------------------------------------------------------
module ssdfb_mod10k (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssdfb_pkg::scale_t in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ssdfb_pkg::digit_t out_o
);

  logic        v3_q, v3_d, v4_q, v4_d;
  logic        rdy3, rdy4;
  logic [2:0]  op3_q;
  logic [7:0]  addr3_q, seg3_q;
  logic [18:0] x3_q;
  logic [3:0]  lo3_q;
  logic [9:0]  qe3_q;
  logic [37:0] qprod;
  logic [19:0] qmul;
  logic [18:0] r_raw;
  logic [9:0]  r_fix;
  ssdfb_pkg::digit_t s4_q, s4_d;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign in_ready_o = rdy3;
  assign v3_d = rdy3 ? in_valid_i : v3_q;
  assign v4_d = rdy4 ? v3_q : v4_q;

  // n mod 10000 = 16 * ((n >> 4) mod 625) + n[3:0]; estimate is q or q-1
  assign qprod = {19'd0, in_i.n[22:4]} * {19'd0, ssdfb_pkg::RECIP_625};

  assign qmul  = {10'd0, qe3_q} * {10'd0, ssdfb_pkg::DIV_625};
  assign r_raw = x3_q - qmul[18:0];

  always_comb begin
    if (r_raw >= {9'd0, ssdfb_pkg::DIV_625}) begin
      r_fix = r_raw[9:0] - ssdfb_pkg::DIV_625;
    end else begin
      r_fix = r_raw[9:0];
    end
    s4_d.op   = op3_q;
    s4_d.addr = addr3_q;
    s4_d.seg  = seg3_q;
    s4_d.m    = {r_fix, lo3_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      op3_q   <= in_i.op;
      addr3_q <= in_i.addr;
      seg3_q  <= in_i.seg;
      x3_q    <= in_i.n[22:4];
      lo3_q   <= in_i.n[3:0];
      qe3_q   <= qprod[37:28];
    end
    if (rdy4) begin
      s4_q <= s4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_o       = s4_q;

endmodule

/* sv/ssdfb_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdfb_emit
// Byte sequencer: command into frame bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ssdfb_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssdfb_pkg::digit_t in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        byte_o,
  output logic              begin_o,
  output logic              end_o,
  output logic              last_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       begin_q, begin_d, end_q, end_d, last_q, last_d;
  logic       num_q, num_d;     // numeric command in flight
  logic       dp_q, dp_d;
  logic [2:0] idx_q, idx_d, nidx;
  logic [ssdfb_pkg::DIGIT_W-1:0] m_q, m_d, dsrc;
  logic [7:0] seg_next_q, seg_next_d;
  logic       b2_q, b2_d;       // second byte opens its own frame
  logic       load, adv, taken, ddp;
  logic [1:0] daddr;
  logic [29:0] q10_prod;
  logic [10:0] q10;
  logic [13:0] q10x;
  logic [13:0] drem;
  logic [7:0]  segv;

  assign in_ready_o = !out_valid_q || (out_ready_i && last_q);
  assign load  = in_valid_i && in_ready_o;
  assign taken = out_valid_q && out_ready_i;
  assign adv   = taken && !last_q;
  assign nidx  = idx_q + 3'd1;

  // one digit per frame: m mod 10 and m / 10
  assign dsrc  = load ? in_i.m : m_q;
  assign daddr = load ? 2'd3 : (2'd3 - nidx[2:1]);
  assign ddp   = load ? (in_i.op == ssdfb_pkg::OP_SHOW_DEC) : dp_q;
  assign q10_prod = {16'd0, dsrc} * {14'd0, ssdfb_pkg::RECIP_10};
  assign q10   = q10_prod[29:19];
  assign q10x  = {q10[10:0], 3'd0} + {2'd0, q10[10:0], 1'b0};
  assign drem  = dsrc - q10x;
  assign segv  = ssdfb_pkg::seg_lut(drem[3:0]) |
                 ((ddp && daddr == 2'd1) ? ssdfb_pkg::DP_BIT : 8'h00);

  always_comb begin
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    begin_d     = begin_q;
    end_d       = end_q;
    last_d      = last_q;
    num_d       = num_q;
    dp_d        = dp_q;
    idx_d       = idx_q;
    m_d         = m_q;
    seg_next_d  = seg_next_q;
    b2_d        = b2_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = 3'd0;
      num_d       = 1'b0;
      dp_d        = ddp;
      begin_d     = 1'b1;
      end_d       = 1'b1;
      last_d      = 1'b1;
      case (in_i.op)
        ssdfb_pkg::OP_SHOW_INT, ssdfb_pkg::OP_SHOW_DEC: begin
          num_d      = 1'b1;
          byte_d     = {ssdfb_pkg::ADDR_CMD_HI, daddr};
          end_d      = 1'b0;
          last_d     = 1'b0;
          seg_next_d = segv;
          m_d        = {3'd0, q10};
        end
        ssdfb_pkg::OP_RAW: begin
          if (in_i.addr[7:2] == 6'd0) begin
            byte_d     = {ssdfb_pkg::ADDR_CMD_HI, in_i.addr[1:0]};
            end_d      = 1'b0;
            last_d     = 1'b0;
            seg_next_d = in_i.seg;
            b2_d       = 1'b0;
          end else begin
            out_valid_d = 1'b0;
          end
        end
        ssdfb_pkg::OP_DISP_ON: begin
          byte_d = ssdfb_pkg::CMD_DISP_ON;
        end
        ssdfb_pkg::OP_DISP_OFF: begin
          byte_d = ssdfb_pkg::CMD_DISP_OFF;
        end
        ssdfb_pkg::OP_INIT: begin
          byte_d     = ssdfb_pkg::CMD_DATA_SET;
          last_d     = 1'b0;
          seg_next_d = ssdfb_pkg::CMD_DISP_ON;
          b2_d       = 1'b1;
        end
        default: begin
          out_valid_d = 1'b0;
        end
      endcase
    end else if (adv) begin
      idx_d = nidx;
      if (num_q && !nidx[0]) begin
        byte_d     = {ssdfb_pkg::ADDR_CMD_HI, daddr};
        begin_d    = 1'b1;
        end_d      = 1'b0;
        last_d     = 1'b0;
        seg_next_d = segv;
        m_d        = {3'd0, q10};
      end else begin
        byte_d  = seg_next_q;
        begin_d = num_q ? 1'b0 : b2_q;
        end_d   = 1'b1;
        last_d  = num_q ? (nidx == 3'd7) : 1'b1;
      end
    end else if (taken) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    begin_q    <= begin_d;
    end_q      <= end_d;
    last_q     <= last_d;
    num_q      <= num_d;
    dp_q       <= dp_d;
    idx_q      <= idx_d;
    m_q        <= m_d;
    seg_next_q <= seg_next_d;
    b2_q       <= b2_d;
  end

  assign out_valid_o = out_valid_q;
  assign byte_o      = byte_q;
  assign begin_o     = begin_q;
  assign end_o       = end_q;
  assign last_o      = last_q;

`ifndef SYNTH
  a_mid_byte_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !begin_q |-> end_q)
    else $error("byte without frame start does not close its frame");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> end_q)
    else $error("final byte of a command leaves a frame open");

  a_num_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && num_q |-> (begin_q != end_q))
    else $error("digit frame byte marks wrong");

  a_num_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && num_q && !idx_q[0] |-> byte_q[7:2] == ssdfb_pkg::ADDR_CMD_HI)
    else $error("digit frame does not open with an address byte");

  a_num_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && num_q && last_q |-> idx_q == 3'd7)
    else $error("numeric command ends before its eighth byte");
`endif

endmodule

/* sv/seven_segment_display_frame_builder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_display_frame_builder_unit
// Turns display commands into the byte stream of a four-digit LED driver.
// ----------------------------------------------------------------------------
// Each command word gives the frame bytes it causes on the master side, one
// byte per cycle while m_axis_tready holds, tagged with frame start and stop
// marks and tlast on the final byte of the command. Numeric commands give
// eight bytes, address 3 (least significant digit) first; raw write gives
// two, display on/off one, init two; a raw write above address 3 and the
// unused codes give nothing. A word runs through four registered stages
// (input, scale, divide estimate, modulo correction) before the byte
// sequencer, whose output register then presents the first byte. The
// sequencer sets the rate: it takes a new command when idle or as the last
// byte of the current one is taken; commands that give nothing pass at one
// per cycle. The stages in front keep taking words, until full, while it is busy.
// ----------------------------------------------------------------------------
module seven_segment_display_frame_builder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[23:0], digit_addr[31:24], segments[39:32]
  input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // tx_byte[7:0]
  output logic [1:0]  m_axis_tuser,  // frame_begin[0], frame_end[1]
  output logic        m_axis_tlast   // last byte of the command
);

  // stage handshakes between the parts
  logic              sc_valid, sc_ready;
  logic              md_valid, md_ready;
  ssdfb_pkg::scale_t sc_word;
  ssdfb_pkg::digit_t md_word;

  // input register and hundredths scaling
  ssdfb_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .value_i     (s_axis_tdata[23:0]),
    .addr_i      (s_axis_tdata[31:24]),
    .seg_i       (s_axis_tdata[39:32]),
    .out_valid_o (sc_valid),
    .out_ready_i (sc_ready),
    .out_o       (sc_word)
  );

  // modulo 10000 reduction
  ssdfb_mod10k u_mod10k (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sc_valid),
    .in_ready_o  (sc_ready),
    .in_i        (sc_word),
    .out_valid_o (md_valid),
    .out_ready_i (md_ready),
    .out_o       (md_word)
  );

  // frame byte sequencer with the output register
  ssdfb_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (md_valid),
    .in_ready_o  (md_ready),
    .in_i        (md_word),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .byte_o      (m_axis_tdata),
    .begin_o     (m_axis_tuser[0]),
    .end_o       (m_axis_tuser[1]),
    .last_o      (m_axis_tlast)
  );

endmodule
